[src/gdc_pkg.sv]
// Shared types and constants for the grid divergence monitor.
package gdc_pkg;

    localparam int COORD_W   = 32;
    localparam int GW_W      = 11;
    localparam int GH_W      = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 13;
    localparam int SUM_W     = 56;
    localparam int DIV_NUM_W = 56;
    localparam int DIV_DEN_W = 33;
    localparam int COUNT_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    typedef struct packed {
        logic signed [COORD_W-1:0] u_value;
        logic signed [COORD_W-1:0] v_value;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
    } t_in_item;

    typedef struct packed {
        logic [COORD_W-1:0] max_divergence;
        logic [COORD_W-1:0] mean_divergence;
        logic               spacing_fault;
    } t_out_item;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD1,
        S_RD2,
        S_T1,
        S_W1,
        S_T2,
        S_W2,
        S_ACC,
        S_NEXT,
        S_MEAN,
        S_WM,
        S_EMIT
    } t_state;

endpackage

[src/gdc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
module gdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/gdc_div.sv]
// Restoring unsigned divider, one quotient bit per cycle.
module gdc_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  gdc_pkg::t_div_req i_req,
    output gdc_pkg::t_div_rsp o_rsp
);

    localparam int NW = gdc_pkg::DIV_NUM_W;
    localparam int DW = gdc_pkg::DIV_DEN_W;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [NW-1:0] r_quo;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;

    logic [DW:0]   rem_sh;
    logic [DW+1:0] diff;
    logic          qbit;
    logic [DW:0]   n_rem;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem[DW-1:0], r_quo[NW-1]};
        diff   = {1'b0, rem_sh} - {2'b00, r_den};
        qbit   = ~diff[DW+1];
        n_rem  = qbit ? diff[DW:0] : rem_sh;
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], qbit};
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

[src/grid_divergence_central_max_mean_top.sv]
// Top level of the grid divergence monitor: sequencer, line stores, accumulators.
//
// Grid points enter on the input channel (i_in_valid / o_in_stall) in raster
// order, one beat per point. For each interior point the block forms
// du/dx + dv/dy by central differences over the non-uniform spacing and
// keeps the maximum and the sum of the absolute value. The beat for the
// last point of a field produces one result beat on the output channel
// (o_out_valid / i_out_stall): max, truncated mean and the spacing fault.
// Points are handled one at a time. A point that completes an interior
// evaluation uses the shared bit-serial divider once per slope term (two
// terms). The last point of a field adds a further division for the mean.
// Input is taken again while a result beat still waits in the output
// register; a stalled result holds until taken. A second result that
// finds the output register full waits before the next point is taken.
// Reset (synchronous, active low) sets grid_width to 1024, grid_height to
// 4096 and starts a new field; no clearing pass is run. A configuration
// write to grid_width or grid_height restarts the field.
module grid_divergence_central_max_mean_top #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  gdc_pkg::t_in_item                   i_in_item,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output gdc_pkg::t_out_item                  o_out_item,
    input  logic                                i_cfg_we,
    input  logic [gdc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [gdc_pkg::CFG_DAT_W-1:0]       i_cfg_data
);

    localparam int AW  = $clog2(MAX_WIDTH);
    localparam int CW  = gdc_pkg::COORD_W;
    localparam int GWW = gdc_pkg::GW_W;
    localparam int GHW = gdc_pkg::GH_W;
    localparam int SW  = gdc_pkg::SUM_W;
    localparam int NW  = gdc_pkg::DIV_NUM_W;
    localparam int DW  = gdc_pkg::DIV_DEN_W;
    localparam int KW  = gdc_pkg::COUNT_W;

    gdc_pkg::t_state    r_state, n_state;
    gdc_pkg::t_in_item  r_item;
    gdc_pkg::t_out_item r_out;
    gdc_pkg::t_div_req  div_req;
    gdc_pkg::t_div_rsp  div_rsp;

    logic [GWW-1:0]       r_gw;
    logic [GHW-1:0]       r_gh;
    logic [GWW-1:0]       r_col;
    logic [GHW-1:0]       r_row;
    logic [CW-1:0]        r_max;
    logic [SW-1:0]        r_sum;
    logic                 r_fault;
    logic                 r_out_valid;
    logic signed [CW-1:0] r_y0, r_y1;
    logic signed [CW-1:0] r_u_left;
    logic signed [CW-1:0] r_u_c1, r_x_c1;
    logic signed [CW:0]   r_du, r_dx, r_dv, r_dy;
    logic signed [CW-1:0] r_t1, r_t2;
    logic [KW-1:0]        r_count;
    logic [CW-1:0]        r_mean;

    logic [GWW-1:0] w_eff;
    logic [GHW-1:0] h_eff;
    logic           in_acc;
    logic           out_acc;
    logic           last_col, last_row;

    // Memory ports: row store holds {u, v older, v newer}; column store holds x
    logic [AW-1:0]     rd_addr_a, rd_addr_b, wr_addr;
    logic              ram_we;
    logic [3*CW-1:0]   ram_a_wdata, ram_a_rdata;
    logic [CW-1:0]     ram_b_rdata;

    logic signed [CW-1:0] a_u, a_vold, a_vnew;
    logic [CW:0]          mag_num;
    logic signed [CW:0]   d_sum;
    logic [CW:0]          d_abs;
    logic [CW-1:0]        a_sat;
    logic [SW:0]          sum_ext;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_out_valid && !i_out_stall;
    assign o_in_stall  = (r_state != gdc_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // Clamp the grid size registers to their usable range
    always_comb begin
        if (r_gw < GWW'(3)) begin
            w_eff = GWW'(3);
        end else if (int'(r_gw) > MAX_WIDTH) begin
            w_eff = GWW'(MAX_WIDTH);
        end else begin
            w_eff = r_gw;
        end
        if (r_gh < GHW'(3)) begin
            h_eff = GHW'(3);
        end else if (int'(r_gh) > MAX_HEIGHT) begin
            h_eff = GHW'(MAX_HEIGHT);
        end else begin
            h_eff = r_gh;
        end
    end

    assign last_col = ({1'b0, r_col} + (GWW+1)'(1)) >= {1'b0, w_eff};
    assign last_row = ({1'b0, r_row} + (GHW+1)'(1)) >= {1'b0, h_eff};

    // Address the stores: column c+1 first, then c (and c-1 for x)
    always_comb begin
        if (r_state == gdc_pkg::S_RD1) begin
            rd_addr_a = AW'(r_col);
            rd_addr_b = AW'(r_col - GWW'(1));
        end else begin
            rd_addr_a = AW'(r_col + GWW'(1));
            rd_addr_b = AW'(r_col + GWW'(1));
        end
    end

    assign a_u    = ram_a_rdata[3*CW-1:2*CW];
    assign a_vold = ram_a_rdata[2*CW-1:CW];
    assign a_vnew = ram_a_rdata[CW-1:0];

    assign ram_we      = (r_state == gdc_pkg::S_RD2);
    assign wr_addr     = AW'(r_col);
    assign ram_a_wdata = {r_item.u_value, a_vnew, r_item.v_value};

    gdc_ram #(.WIDTH(3*CW), .DEPTH(MAX_WIDTH)) u_ram_row (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (ram_a_wdata),
        .i_raddr (rd_addr_a),
        .o_rdata (ram_a_rdata)
    );

    gdc_ram #(.WIDTH(CW), .DEPTH(MAX_WIDTH)) u_ram_col (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_addr),
        .i_wdata (r_item.x_coord),
        .i_raddr (rd_addr_b),
        .o_rdata (ram_b_rdata)
    );

    // Divider requests: the two slope terms, then the mean
    always_comb begin
        div_req = '0;
        if (r_state == gdc_pkg::S_T1) begin
            mag_num          = r_du[CW] ? (CW+1)'(-r_du) : r_du;
            div_req.start    = !(r_dx[CW] || (r_dx == '0));
            div_req.dividend = {(NW-CW-17)'(0), mag_num, 16'h0};
            div_req.divisor  = r_dx;
        end else if (r_state == gdc_pkg::S_T2) begin
            mag_num          = r_dv[CW] ? (CW+1)'(-r_dv) : r_dv;
            div_req.start    = !(r_dy[CW] || (r_dy == '0));
            div_req.dividend = {(NW-CW-17)'(0), mag_num, 16'h0};
            div_req.divisor  = r_dy;
        end else begin
            mag_num          = '0;
            div_req.start    = (r_state == gdc_pkg::S_MEAN);
            div_req.dividend = NW'(r_sum);
            div_req.divisor  = DW'(r_count);
        end
    end

    gdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Saturate a quotient magnitude to a signed 32-bit term
    function automatic logic signed [CW-1:0] sat_term(input logic [NW-1:0] mag,
                                                      input logic neg);
        logic signed [CW-1:0] res;
        if (!neg) begin
            res = (mag > NW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : CW'(mag);
        end else begin
            res = (mag > NW'(32'h8000_0000)) ? 32'sh8000_0000 : CW'(-mag);
        end
        return res;
    endfunction

    // Interior test for the point being stepped
    function automatic logic r_interior_next();
        return (r_row >= GHW'(2)) && (r_col >= GWW'(1)) && !last_col;
    endfunction

    // Absolute divergence and saturated sum
    always_comb begin
        d_sum   = (CW+1)'(r_t1) + (CW+1)'(r_t2);
        d_abs   = d_sum[CW] ? (CW+1)'(-d_sum) : d_sum;
        a_sat   = d_abs[CW] ? '1 : d_abs[CW-1:0];
        sum_ext = {1'b0, r_sum} + (SW+1)'(a_sat);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            gdc_pkg::S_IDLE: if (in_acc) n_state = gdc_pkg::S_RD1;
            gdc_pkg::S_RD1:  n_state = gdc_pkg::S_RD2;
            gdc_pkg::S_RD2:  n_state = r_interior_next() ? gdc_pkg::S_T1 : gdc_pkg::S_NEXT;
            gdc_pkg::S_T1:   n_state = div_req.start ? gdc_pkg::S_W1 : gdc_pkg::S_T2;
            gdc_pkg::S_W1:   if (div_rsp.done) n_state = gdc_pkg::S_T2;
            gdc_pkg::S_T2:   n_state = div_req.start ? gdc_pkg::S_W2 : gdc_pkg::S_ACC;
            gdc_pkg::S_W2:   if (div_rsp.done) n_state = gdc_pkg::S_ACC;
            gdc_pkg::S_ACC:  n_state = gdc_pkg::S_NEXT;
            gdc_pkg::S_NEXT: begin
                n_state = (last_col && last_row) ? gdc_pkg::S_MEAN : gdc_pkg::S_IDLE;
            end
            gdc_pkg::S_MEAN: n_state = gdc_pkg::S_WM;
            gdc_pkg::S_WM:   if (div_rsp.done) n_state = gdc_pkg::S_EMIT;
            gdc_pkg::S_EMIT: if (!r_out_valid || !i_out_stall) n_state = gdc_pkg::S_IDLE;
            default:         n_state = gdc_pkg::S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gdc_pkg::S_IDLE;
            r_gw        <= GWW'(1024);
            r_gh        <= GHW'(4096);
            r_col       <= '0;
            r_row       <= '0;
            r_max       <= '0;
            r_sum       <= '0;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
            r_y0        <= '0;
            r_y1        <= '0;
            r_u_left    <= '0;
        end else begin
            r_state <= n_state;
            // Drop the taken beat unless a new result loads in its place
            if (out_acc && r_state != gdc_pkg::S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            // Configuration write to the width or height restarts the field
            if (i_cfg_we) begin
                if (i_cfg_index == gdc_pkg::CFG_GRID_WIDTH) begin
                    r_gw <= i_cfg_data[GWW-1:0];
                end
                if (i_cfg_index == gdc_pkg::CFG_GRID_WIDTH ||
                    i_cfg_index == gdc_pkg::CFG_GRID_HEIGHT) begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_max   <= '0;
                    r_sum   <= '0;
                    r_fault <= 1'b0;
                end
                if (i_cfg_index == gdc_pkg::CFG_GRID_HEIGHT) begin
                    r_gh <= i_cfg_data[GHW-1:0];
                end
            end
            case (r_state)
                gdc_pkg::S_RD2: r_u_left <= a_u;
                gdc_pkg::S_T1:  if (!div_req.start) r_fault <= 1'b1;
                gdc_pkg::S_T2:  if (!div_req.start) r_fault <= 1'b1;
                gdc_pkg::S_ACC: begin
                    if (a_sat > r_max) r_max <= a_sat;
                    r_sum <= sum_ext[SW] ? '1 : sum_ext[SW-1:0];
                end
                gdc_pkg::S_NEXT: begin
                    if (last_col) begin
                        r_y0 <= r_y1;
                        r_y1 <= r_item.y_coord;
                        if (!last_row) begin
                            r_row <= r_row + GHW'(1);
                            r_col <= '0;
                        end
                    end else begin
                        r_col <= r_col + GWW'(1);
                    end
                end
                gdc_pkg::S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid <= 1'b1;
                        r_col   <= '0;
                        r_row   <= '0;
                        r_max   <= '0;
                        r_sum   <= '0;
                        r_fault <= 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in_item;
        end
        case (r_state)
            gdc_pkg::S_RD1: begin
                r_u_c1 <= a_u;
                r_x_c1 <= ram_b_rdata;
            end
            gdc_pkg::S_RD2: begin
                r_du <= (CW+1)'(r_u_c1) - (CW+1)'(r_u_left);
                r_dx <= (CW+1)'(r_x_c1) - (CW+1)'($signed(ram_b_rdata));
                r_dv <= (CW+1)'(r_item.v_value) - (CW+1)'(a_vold);
                r_dy <= (CW+1)'(r_item.y_coord) - (CW+1)'(r_y0);
            end
            gdc_pkg::S_T1: if (!div_req.start) r_t1 <= '0;
            gdc_pkg::S_W1: if (div_rsp.done) r_t1 <= sat_term(div_rsp.quotient, r_du[CW]);
            gdc_pkg::S_T2: if (!div_req.start) r_t2 <= '0;
            gdc_pkg::S_W2: if (div_rsp.done) r_t2 <= sat_term(div_rsp.quotient, r_dv[CW]);
            gdc_pkg::S_NEXT: r_count <= (KW'(w_eff) - KW'(2)) * (KW'(h_eff) - KW'(2));
            gdc_pkg::S_WM: begin
                if (div_rsp.done) begin
                    r_mean <= (div_rsp.quotient > NW'(32'hFFFF_FFFF)) ? '1
                                                                      : CW'(div_rsp.quotient);
                end
            end
            gdc_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    r_out.max_divergence  <= r_max;
                    r_out.mean_divergence <= r_mean;
                    r_out.spacing_fault   <= r_fault;
                end
            end
            default: begin
            end
        endcase
    end

    // An accepted beat starts the store reads
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_state == gdc_pkg::S_RD1)
        else $error("accepted beat did not start the store reads");

    // Counters stay inside the grid
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col < w_eff) && (r_row < h_eff))
        else $error("grid counter out of range");

    // A result load leaves the field restarted
    a_emit_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == gdc_pkg::S_EMIT && (!r_out_valid || !i_out_stall) && !i_cfg_we)
        |=> (o_out_valid && r_col == '0 && r_row == '0 && r_sum == '0))
        else $error("result load did not restart the field");

    // Stores are written only on the second read cycle of a point
    a_write_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> $past(r_state) == gdc_pkg::S_RD1)
        else $error("store written out of sequence");

endmodule

[tb/gdc_checker.sv]
// Scoreboard for the grid divergence monitor: field predictor and result compare.
module gdc_checker #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  gdc_pkg::t_in_item             i_in_item,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  gdc_pkg::t_out_item            i_out_item,
    input  logic                          i_cfg_we,
    input  logic [gdc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [gdc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_results_pending
);

    localparam longint unsigned SUM_CAP = (64'd1 << 56) - 64'd1;

    // predicted block state
    logic [gdc_pkg::GW_W-1:0]  width_reg;
    logic [gdc_pkg::GH_W-1:0]  height_reg;
    logic signed [31:0]        u_line   [MAX_WIDTH];
    logic signed [31:0]        v_older  [MAX_WIDTH];
    logic signed [31:0]        v_newer  [MAX_WIDTH];
    logic signed [31:0]        x_line   [MAX_WIDTH];
    logic signed [31:0]        y_hist   [2];
    logic signed [31:0]        u_upleft;
    int unsigned               col_pos;
    int unsigned               row_pos;
    logic [31:0]               peak_div;
    longint unsigned           div_total;
    bit                        spacing_bad;
    gdc_pkg::t_out_item        field_results_q [$];
    int                        reported;

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // one slope term: scaled quotient, saturated; bad spacing gives zero
    function automatic longint slope_term(longint num, longint den);
        longint q;
        if (den <= 0) begin
            spacing_bad = 1'b1;
            return 0;
        end
        q = (num * 65536) / den;
        if (q > 64'sh7FFFFFFF) q = 64'sh7FFFFFFF;
        if (q < -64'sh80000000) q = -64'sh80000000;
        return q;
    endfunction

    task automatic restart_field();
        col_pos     = 0;
        row_pos     = 0;
        peak_div    = '0;
        div_total   = 0;
        spacing_bad = 1'b0;
    endtask

    // advance the predictor by one accepted grid point
    task automatic take_point(input gdc_pkg::t_in_item it);
        int unsigned        w;
        int unsigned        h;
        int unsigned        c;
        int unsigned        r;
        longint             d;
        longint unsigned    a;
        longint unsigned    mean;
        gdc_pkg::t_out_item res;
        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        c = col_pos;
        r = row_pos;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        if (r >= 2 && c >= 1 && c + 1 < w) begin
            d = slope_term(longint'(u_line[c+1]) - longint'(u_upleft),
                           longint'(x_line[c+1]) - longint'(x_line[c-1]))
              + slope_term(longint'(it.v_value) - longint'(v_older[c]),
                           longint'(it.y_coord) - longint'(y_hist[0]));
            a = (d < 0) ? longint'(-d) : longint'(d);
            if (a > 64'hFFFFFFFF) a = 64'hFFFFFFFF;
            if (a[31:0] > peak_div) peak_div = a[31:0];
            div_total = div_total + a;
            if (div_total > SUM_CAP) div_total = SUM_CAP;
        end
        u_upleft   = u_line[c];
        u_line[c]  = it.u_value;
        v_older[c] = v_newer[c];
        v_newer[c] = it.v_value;
        x_line[c]  = it.x_coord;
        if (c + 1 >= w) begin
            y_hist[0] = y_hist[1];
            y_hist[1] = it.y_coord;
            if (r + 1 >= h) begin
                mean = div_total / (longint'(w - 2) * longint'(h - 2));
                if (mean > 64'hFFFFFFFF) mean = 64'hFFFFFFFF;
                res.max_divergence  = peak_div;
                res.mean_divergence = mean[31:0];
                res.spacing_fault   = spacing_bad;
                field_results_q.push_back(res);
                restart_field();
            end else begin
                row_pos = r + 1;
                col_pos = 0;
            end
        end else begin
            row_pos = r;
            col_pos = c + 1;
        end
    endtask

    // compare one result beat with the oldest expectation
    task automatic check_result(input gdc_pkg::t_out_item got);
        gdc_pkg::t_out_item want;
        if (field_results_q.size() == 0) begin
            o_fail_count <= o_fail_count + 1;
            if (reported < 10)
                $display("%0t: unexpected result max=%h mean=%h fault=%b", $realtime,
                         got.max_divergence, got.mean_divergence, got.spacing_fault);
            reported++;
            return;
        end
        want = field_results_q.pop_front();
        if (got !== want) begin
            o_fail_count <= o_fail_count + 1;
            if (reported < 10)
                $display("%0t: result mismatch exp max=%h mean=%h fault=%b got max=%h mean=%h fault=%b",
                         $realtime, want.max_divergence, want.mean_divergence,
                         want.spacing_fault, got.max_divergence, got.mean_divergence,
                         got.spacing_fault);
            reported++;
        end
    endtask

    initial begin
        o_fail_count      = 0;
        o_results_pending = 0;
        reported          = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg  <= (gdc_pkg::GW_W)'(1024);
            height_reg <= (gdc_pkg::GH_W)'(4096);
            y_hist[0]  = '0;
            y_hist[1]  = '0;
            u_upleft   = '0;
            restart_field();
            field_results_q.delete();
        end else begin
            // hold register writes; an unused index leaves the field running
            if (i_cfg_we) begin
                if (i_cfg_index == gdc_pkg::CFG_GRID_WIDTH) begin
                    width_reg <= i_cfg_data[gdc_pkg::GW_W-1:0];
                    restart_field();
                end else if (i_cfg_index == gdc_pkg::CFG_GRID_HEIGHT) begin
                    height_reg <= i_cfg_data[gdc_pkg::GH_W-1:0];
                    restart_field();
                end
            end
            if (i_in_valid && !i_in_stall) take_point(i_in_item);
            if (i_out_valid && !i_out_stall) check_result(i_out_item);
        end
        o_results_pending <= field_results_q.size();
    end

endmodule

[tb/testbench.sv]
// Testbench top: clock, reset, grid field stimulus and the final verdict.
module testbench;

    localparam logic [gdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [gdc_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam longint CYCLE_LIMIT  = 64'd4_000_000;
    localparam int     SETTLE_TICKS = 300;

    typedef enum int {FM_CLEAN, FM_BAD, FM_EXTREME, FM_FLAT, FM_NOISE} t_field_mode;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    gdc_pkg::t_in_item              in_item   = '0;
    logic                           out_stall = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [gdc_pkg::CFG_IDX_W-1:0]  cfg_index = gdc_pkg::CFG_GRID_WIDTH;
    logic [gdc_pkg::CFG_DAT_W-1:0]  cfg_data  = '0;
    logic                           in_stall;
    logic                           out_valid;
    gdc_pkg::t_out_item             out_item;
    int                             fail_count;
    int                             results_pending;
    int                             send_idle_pct = 0;
    int                             stall_pct     = 0;
    longint                         cycles        = 0;
    int                             points_sent   = 0;
    int unsigned                    cur_w;
    int unsigned                    cur_h;

    grid_divergence_central_max_mean_top uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    gdc_checker field_check (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_item         (in_item),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_item        (out_item),
        .i_cfg_we          (cfg_we),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_fail_count      (fail_count),
        .o_results_pending (results_pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // stall the result channel at random
    always @(posedge clk) out_stall <= (stall_pct != 0) && ($urandom_range(0, 99) < stall_pct);

    // abort a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[grid_divergence_central_max_mean_top] ERROR");
            $finish;
        end
    end

    // push one grid point, with random gaps before it
    task automatic send_point(input gdc_pkg::t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        points_sent++;
    endtask

    // wait until the scoreboard has seen every expected result
    task automatic drain_results();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (results_pending != 0) @(posedge clk);
    endtask

    // drain pending results and let the block finish its last point
    task automatic settle();
        drain_results();
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gdc_pkg::CFG_IDX_W-1:0] idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (gdc_pkg::CFG_DAT_W)'(val);
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == gdc_pkg::CFG_GRID_WIDTH) begin
            cur_w = val & 32'h7FF;
            cur_w = (cur_w < 3) ? 3 : (cur_w > 1024) ? 1024 : cur_w;
        end else if (idx == gdc_pkg::CFG_GRID_HEIGHT) begin
            cur_h = val & 32'h1FFF;
            cur_h = (cur_h < 3) ? 3 : (cur_h > 4096) ? 4096 : cur_h;
        end
    endtask

    task automatic set_grid(input int unsigned w_val, input int unsigned h_val);
        settle();
        write_reg(gdc_pkg::CFG_GRID_WIDTH, w_val);
        write_reg(gdc_pkg::CFG_GRID_HEIGHT, h_val);
    endtask

    function automatic logic signed [31:0] rand_velocity();
        return $signed($urandom) >>> $urandom_range(0, 31);
    endfunction

    function automatic int rand_spacing();
        if ($urandom_range(0, 9) == 0) return $urandom_range(1, 8);
        return $urandom_range(1, 32'h30000);
    endfunction

    // stream one field (or its first n_points) in raster order
    task automatic send_field(input t_field_mode mode, input int n_points);
        logic signed [31:0] col_x [1024];
        logic signed [31:0] row_y [4096];
        gdc_pkg::t_in_item  it;
        int                 k;
        int                 n;
        col_x[0] = $urandom_range(0, 32'h00FFFFFF) - 32'h007FFFFF;
        row_y[0] = $urandom_range(0, 32'h00FFFFFF) - 32'h007FFFFF;
        for (int c = 1; c < cur_w; c++)
            col_x[c] = (mode == FM_FLAT) ? col_x[0] :
                       (mode == FM_EXTREME) ? col_x[c-1] + 1 : col_x[c-1] + rand_spacing();
        for (int r = 1; r < cur_h; r++)
            row_y[r] = (mode == FM_FLAT) ? row_y[r-1] - 32'sh10000 :
                       (mode == FM_EXTREME) ? row_y[r-1] + 1 : row_y[r-1] + rand_spacing();
        // break one column spacing and, at random, one row spacing
        if (mode == FM_BAD) begin
            k = $urandom_range(1, cur_w - 1);
            col_x[k] = col_x[k-1] - $urandom_range(0, 2) * 32'h10000;
            if ($urandom_range(0, 1)) begin
                k = $urandom_range(1, cur_h - 1);
                row_y[k] = row_y[k-1] - $urandom_range(0, 2) * 32'h10000;
            end
        end
        n = 0;
        for (int r = 0; r < cur_h; r++) begin
            for (int c = 0; c < cur_w; c++) begin
                if (n_points >= 0 && n >= n_points) return;
                if (mode == FM_NOISE) begin
                    it.u_value = $urandom;
                    it.v_value = $urandom;
                    it.x_coord = $urandom;
                    it.y_coord = $urandom;
                end else if (mode == FM_EXTREME) begin
                    it.u_value = ((c + r) % 2) ? 32'sh7FFFFFFF : -32'sh80000000;
                    it.v_value = ((c + r) % 2) ? -32'sh80000000 : 32'sh7FFFFFFF;
                    it.x_coord = col_x[c];
                    it.y_coord = row_y[r];
                end else begin
                    it.u_value = rand_velocity();
                    it.v_value = rand_velocity();
                    it.x_coord = col_x[c];
                    it.y_coord = row_y[r];
                end
                send_point(it);
                n++;
            end
        end
    endtask

    initial begin
        int          phase;
        int          n_fields;
        int          pick;
        t_field_mode mode;
        cur_w = 1024;
        cur_h = 4096;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: saturating extremes, then zero and negative spacing
        set_grid(3, 3);
        send_field(FM_EXTREME, -1);
        send_field(FM_FLAT, -1);

        // unused register index mid-field leaves the field running
        set_grid(4, 4);
        send_field(FM_CLEAN, 7);
        settle();
        write_reg(CFG_SPARE_A, $urandom_range(0, 8191));
        write_reg(CFG_SPARE_B, $urandom_range(0, 8191));
        send_field(FM_CLEAN, -1);

        // random fields over the idling phases
        phase = 0;
        while (points_sent < 1500) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 78; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 78; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            if ($urandom_range(0, 9) == 0)
                set_grid($urandom_range(0, 2), $urandom_range(3, 8));
            else if ($urandom_range(0, 9) == 0)
                set_grid($urandom_range(3, 8), $urandom_range(0, 2));
            else
                set_grid($urandom_range(3, 8), $urandom_range(3, 8));
            n_fields = $urandom_range(1, 4);
            for (int f = 0; f < n_fields; f++) begin
                pick = $urandom_range(0, 99);
                mode = (pick < 70) ? FM_CLEAN : (pick < 82) ? FM_BAD :
                       (pick < 85) ? FM_EXTREME : FM_NOISE;
                send_field(mode, -1);
                // at random, pause until every result is out
                if ($urandom_range(0, 7) == 0) begin
                    drain_results();
                end
            end
            phase++;
        end

        // largest sizes through out-of-range register values, first rows only
        send_idle_pct = 0;
        stall_pct     = 0;
        set_grid(2047, 3);
        send_field(FM_CLEAN, 300);
        set_grid(3, 8191);
        send_field(FM_BAD, 200);

        settle();
        if (fail_count == 0) begin
            $display("[grid_divergence_central_max_mean_top] OK");
        end else begin
            $display("[grid_divergence_central_max_mean_top] ERROR");
        end
        $finish;
    end

endmodule
